// ===== design/tclw_pkg.sv =====
// Shared types and constants for the text console line writer.
package tclw_pkg;

  // Field widths
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ROW_W      = 15;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned WL_W       = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LW_W       = 8;
  localparam int unsigned TL_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CAP_W      = 17;
  localparam int unsigned SLOT_MAX_W = 4;
  localparam int unsigned OUT_SLOT_W = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_COLOR_A = 8'd1;
  localparam logic [CHAR_W-1:0] CHAR_COLOR_B = 8'd2;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] COLOR_MASK   = 8'h80;

  // Reset values of the registers and the ring position
  localparam int unsigned RESET_LINE_WIDTH  = 38;
  localparam int unsigned RESET_TOTAL_LINES = 862;
  localparam int unsigned RESET_ROW         = 861;
  localparam int unsigned ROW_LIMIT         = 32768;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH  = 2'd0,
    REG_TOTAL_LINES = 2'd1,
    REG_OR_MASK     = 2'd2
  } cfg_reg_e;

  // Classified character operation
  typedef enum logic [1:0] {
    OP_PRINT   = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_RETURN  = 2'd2
  } op_e;

  // Result command kind
  typedef enum logic {
    KIND_CLEAR = 1'b0,
    KIND_STORE = 1'b1
  } kind_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic              color;
    logic [WL_W-1:0]   word_length;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic [CHAR_W-1:0]     char_value;
    logic [OUT_SLOT_W-1:0] notify_slot;
    logic [TIME_W-1:0]     stamp_time;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [LW_W-1:0]       width;
    logic [ROW_W-1:0]      n_m1;
    logic [CHAR_W-1:0]     or_mask;
    logic                  busy;
    logic                  load;
    logic [ROW_W-1:0]      load_row;
    logic [SLOT_MAX_W-1:0] load_slot;
  } cfg_t;

endpackage

// ===== design/tclw_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
module tclw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/tclw_cfg.sv =====
// Configuration registers and ring length / notify slot sequencer.
module tclw_cfg #(
  parameter int unsigned TEXT_SIZE    = 32768,
  parameter int unsigned NOTIFY_SLOTS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tclw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tclw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output tclw_pkg::cfg_t                     cfg_o
);

  localparam int unsigned ResetCap  = TEXT_SIZE / tclw_pkg::RESET_LINE_WIDTH;
  localparam int unsigned ResetN0   = (tclw_pkg::RESET_TOTAL_LINES < ResetCap) ?
                                      tclw_pkg::RESET_TOTAL_LINES : ResetCap;
  localparam int unsigned ResetN    = (ResetN0 < tclw_pkg::ROW_LIMIT) ?
                                      ResetN0 : tclw_pkg::ROW_LIMIT;
  localparam int unsigned RecipK    = 20;
  localparam int unsigned RecipM    = ((1 << RecipK) + NOTIFY_SLOTS - 1) / NOTIFY_SLOTS;
  localparam int unsigned ProdW     = 36;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_SIZE = 4'b0010,
    SEQ_DIV  = 4'b0100,
    SEQ_SLOT = 4'b1000
  } seq_e;

  seq_e                             seq_q, seq_d;
  logic [tclw_pkg::LW_W-1:0]        line_width_q;
  logic [tclw_pkg::TL_W-1:0]        total_lines_q;
  logic [tclw_pkg::CHAR_W-1:0]      or_mask_q;
  logic [tclw_pkg::ROW_W-1:0]       n_m1_q;
  logic [tclw_pkg::ROW_W-1:0]       rl_row_q;
  logic [tclw_pkg::ROW_W-1:0]       quot_q;
  logic                             reload_q;
  logic                             load_pend_q;
  logic [tclw_pkg::CAP_W-1:0]       cap_tbl [256];
  logic [tclw_pkg::LW_W-1:0]        eff_width;
  logic [tclw_pkg::CAP_W-1:0]       eff_lines, capped, n_full;
  logic [tclw_pkg::ROW_W-1:0]       n_m1;
  logic [ProdW-1:0]                 recip_prod;
  logic [tclw_pkg::ROW_W-1:0]       quot_scaled, slot_rem;

  // Build the lines-per-text table, one entry per line width
  for (genvar gi = 0; gi < 256; gi++) begin : g_cap
    localparam int unsigned Div = (gi == 0) ? 1 : gi;
    localparam int unsigned Cap = TEXT_SIZE / Div;
    assign cap_tbl[gi] = tclw_pkg::CAP_W'(Cap);
  end

  // Work out the ring length in use
  always_comb begin
    eff_width = (line_width_q == '0) ? tclw_pkg::LW_W'(1) : line_width_q;
    eff_lines = (total_lines_q == '0) ? tclw_pkg::CAP_W'(1) :
                {1'b0, total_lines_q};
    capped    = (eff_lines > cap_tbl[eff_width]) ? cap_tbl[eff_width] : eff_lines;
    n_full    = (capped > tclw_pkg::CAP_W'(tclw_pkg::ROW_LIMIT)) ?
                tclw_pkg::CAP_W'(tclw_pkg::ROW_LIMIT) : capped;
    n_m1      = tclw_pkg::ROW_W'(n_full - 1'b1);
  end

  // Slot of the last row: remainder by reciprocal multiply
  assign recip_prod  = ProdW'(rl_row_q) * ProdW'(RecipM);
  assign quot_scaled = tclw_pkg::ROW_W'(quot_q * tclw_pkg::ROW_W'(NOTIFY_SLOTS));
  assign slot_rem    = rl_row_q - quot_scaled;

  // Step the sequencer; any write restarts it
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE: seq_d = SEQ_IDLE;
      SEQ_SIZE: seq_d = (reload_q || load_pend_q) ? SEQ_DIV : SEQ_IDLE;
      SEQ_DIV:  seq_d = SEQ_SLOT;
      SEQ_SLOT: seq_d = SEQ_IDLE;
      default:  seq_d = SEQ_IDLE;
    endcase
    if (cfg_we_i) begin
      seq_d = SEQ_SIZE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= SEQ_IDLE;
      line_width_q  <= tclw_pkg::LW_W'(tclw_pkg::RESET_LINE_WIDTH);
      total_lines_q <= tclw_pkg::TL_W'(tclw_pkg::RESET_TOTAL_LINES);
      or_mask_q     <= '0;
      n_m1_q        <= tclw_pkg::ROW_W'(ResetN - 1);
      reload_q      <= 1'b0;
      load_pend_q   <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == SEQ_SIZE) begin
        n_m1_q <= n_m1;
        if (reload_q) begin
          load_pend_q <= 1'b1;
        end
      end
      if (seq_q == SEQ_SLOT) begin
        load_pend_q <= 1'b0;
      end
      // Flag a ring length write until the size stage picks it up
      if (cfg_we_i && (cfg_index_i == tclw_pkg::REG_TOTAL_LINES)) begin
        reload_q <= 1'b1;
      end else if (seq_q == SEQ_SIZE) begin
        reload_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          tclw_pkg::REG_LINE_WIDTH:  line_width_q  <= cfg_data_i[tclw_pkg::LW_W-1:0];
          tclw_pkg::REG_TOTAL_LINES: total_lines_q <= cfg_data_i[tclw_pkg::TL_W-1:0];
          tclw_pkg::REG_OR_MASK:     or_mask_q     <= cfg_data_i[tclw_pkg::CHAR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Hold the reload row and its quotient
  always_ff @(posedge clk_i) begin
    if (seq_q == SEQ_SIZE && reload_q) begin
      rl_row_q <= n_m1;
    end
    if (seq_q == SEQ_DIV) begin
      quot_q <= recip_prod[RecipK +: tclw_pkg::ROW_W];
    end
  end

  always_comb begin
    cfg_o.width     = eff_width;
    cfg_o.n_m1      = n_m1_q;
    cfg_o.or_mask   = or_mask_q;
    cfg_o.busy      = cfg_we_i || (seq_q != SEQ_IDLE);
    cfg_o.load      = (seq_q == SEQ_SLOT) && load_pend_q;
    cfg_o.load_row  = rl_row_q;
    cfg_o.load_slot = tclw_pkg::SLOT_MAX_W'(slot_rem);
  end

endmodule

// ===== design/tclw_front.sv =====
// Front end: accept characters, drop nulls and color markers, tag color.
module tclw_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           message_start_i,
  input  logic [tclw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tclw_pkg::WL_W-1:0]      word_length_i,
  input  logic [tclw_pkg::TIME_W-1:0]    now_ms_i,
  input  logic                           busy_i,
  input  logic                           q_full_i,
  output logic                           full_o,
  output logic                           q_push_o,
  output tclw_pkg::item_t                q_item_o
);

  logic color_q, color_d;
  logic accept, is_null, is_marker;

  assign full_o    = q_full_i || busy_i;
  assign accept    = in_valid_i && !full_o;
  assign is_null   = (char_code_i == tclw_pkg::CHAR_NULL);
  assign is_marker = message_start_i && ((char_code_i == tclw_pkg::CHAR_COLOR_A) ||
                                         (char_code_i == tclw_pkg::CHAR_COLOR_B));

  // Classify the character and track the message color
  always_comb begin
    color_d               = color_q;
    q_push_o              = 1'b0;
    q_item_o.char_code    = char_code_i;
    q_item_o.word_length  = word_length_i;
    q_item_o.now_ms       = now_ms_i;
    q_item_o.color        = message_start_i ? 1'b0 : color_q;
    q_item_o.op           = tclw_pkg::OP_PRINT;
    if (char_code_i == tclw_pkg::CHAR_NEWLINE) begin
      q_item_o.op = tclw_pkg::OP_NEWLINE;
    end else if (char_code_i == tclw_pkg::CHAR_RETURN) begin
      q_item_o.op = tclw_pkg::OP_RETURN;
    end
    if (accept && !is_null) begin
      if (is_marker) begin
        color_d = 1'b1;
      end else begin
        q_push_o = 1'b1;
        if (message_start_i) begin
          color_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b0;
    end else begin
      color_q <= color_d;
    end
  end

endmodule

// ===== design/tclw_back.sv =====
// Back end: cursor and ring state, emits clear and store transactions.
module tclw_back #(
  parameter int unsigned NOTIFY_SLOTS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tclw_pkg::cfg_t   cfg_i,
  input  logic             item_valid_i,
  input  tclw_pkg::item_t  item_i,
  output logic             item_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output tclw_pkg::res_t   res_o
);

  localparam int unsigned SlotW     = (NOTIFY_SLOTS > 1) ? $clog2(NOTIFY_SLOTS) : 1;
  localparam int unsigned ResetSlot = tclw_pkg::RESET_ROW % NOTIFY_SLOTS;

  logic [tclw_pkg::COL_W-1:0] cursor_q, cursor_d;
  logic [tclw_pkg::ROW_W-1:0] row_q, row_d;
  logic [SlotW-1:0]           slot_q, slot_d;
  logic                       ret_pend_q, ret_pend_d;
  logic                       pend_q, pend_d;
  tclw_pkg::res_t             pend_res_q;

  logic [tclw_pkg::COL_W-1:0] x_clip, x_col, x_adv;
  logic [tclw_pkg::COL_W:0]   wrap_sum, x_inc;
  logic                       line_start, is_print, take;
  logic [tclw_pkg::ROW_W-1:0] row_clamp, row_inc, row_new;
  logic [SlotW-1:0]           slot_inc, slot_new;
  logic [SlotW+1:0]           slot_ext;
  tclw_pkg::res_t             clear_res, store_res;

  // Pick the column: clip past-end cursor, wrap a word that does not fit
  always_comb begin
    x_clip   = (cursor_q >= cfg_i.width) ? '0 : cursor_q;
    wrap_sum = {1'b0, x_clip} + {1'b0, item_i.word_length};
    x_col    = ((item_i.word_length < cfg_i.width) &&
                (wrap_sum > {1'b0, cfg_i.width})) ? '0 : x_clip;
    x_inc    = {1'b0, x_col} + 1'b1;
    x_adv    = (x_inc >= {1'b0, cfg_i.width}) ? '0 : x_inc[tclw_pkg::COL_W-1:0];
  end

  // Ring row: clamp to ring, advance on a new line; a pending return
  // always meets a new line, so step back and step on cancel out
  always_comb begin
    line_start = (x_col == '0);
    is_print   = (item_i.op == tclw_pkg::OP_PRINT);
    row_clamp  = (row_q > cfg_i.n_m1) ? cfg_i.n_m1 : row_q;
    row_inc    = (row_q >= cfg_i.n_m1) ? '0 : row_q + 1'b1;
    slot_inc   = (slot_q == SlotW'(NOTIFY_SLOTS - 1)) ? '0 : slot_q + 1'b1;
    row_new    = row_clamp;
    slot_new   = slot_q;
    if (line_start && !ret_pend_q) begin
      row_new  = row_inc;
      slot_new = slot_inc;
    end
    slot_ext   = {2'b00, slot_new};
  end

  // Build both transactions
  always_comb begin
    clear_res.kind        = tclw_pkg::KIND_CLEAR;
    clear_res.row         = row_new;
    clear_res.column      = '0;
    clear_res.char_value  = tclw_pkg::CHAR_SPACE;
    clear_res.notify_slot = slot_ext[tclw_pkg::OUT_SLOT_W-1:0];
    clear_res.stamp_time  = item_i.now_ms;
    clear_res.last        = !is_print;
    store_res.kind        = tclw_pkg::KIND_STORE;
    store_res.row         = row_new;
    store_res.column      = x_col;
    store_res.char_value  = item_i.char_code | cfg_i.or_mask |
                            (item_i.color ? tclw_pkg::COLOR_MASK : '0);
    store_res.notify_slot = '0;
    store_res.stamp_time  = '0;
    store_res.last        = 1'b1;
  end

  // Issue: a held store goes first, then the next item
  always_comb begin
    take       = !pend_q && item_valid_i && !res_full_i;
    item_pop_o = take;
    pend_d     = pend_q;
    cursor_d   = cursor_q;
    row_d      = row_q;
    slot_d     = slot_q;
    ret_pend_d = ret_pend_q;
    if (pend_q) begin
      res_push_o = !res_full_i;
      res_o      = pend_res_q;
      if (!res_full_i) begin
        pend_d = 1'b0;
      end
    end else begin
      res_push_o = take && (line_start || is_print);
      res_o      = line_start ? clear_res : store_res;
    end
    if (take) begin
      row_d      = row_new;
      slot_d     = slot_new;
      ret_pend_d = (item_i.op == tclw_pkg::OP_RETURN);
      cursor_d   = is_print ? x_adv : '0;
      pend_d     = line_start && is_print;
    end
    if (cfg_i.load) begin
      row_d  = cfg_i.load_row;
      slot_d = SlotW'(cfg_i.load_slot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      row_q      <= tclw_pkg::ROW_W'(tclw_pkg::RESET_ROW);
      slot_q     <= SlotW'(ResetSlot);
      ret_pend_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      cursor_q   <= cursor_d;
      row_q      <= row_d;
      slot_q     <= slot_d;
      ret_pend_q <= ret_pend_d;
      pend_q     <= pend_d;
    end
  end

  // Hold the store that follows a clear
  always_ff @(posedge clk_i) begin
    if (take && line_start && is_print) begin
      pend_res_q <= store_res;
    end
  end

`ifndef SYNTHESIS
  a_return_at_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_pend_q |-> (cursor_q == '0))
    else $error("return pending with cursor off column zero");

  a_no_pop_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !item_pop_o)
    else $error("item taken while a store is still held");

  a_held_is_final_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((pend_res_q.kind == tclw_pkg::KIND_STORE) && pend_res_q.last))
    else $error("held transaction is not a final store");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("transaction pushed into a full result queue");
`endif

endmodule

// ===== design/text_console_line_writer.sv =====
// Path: an accepted character is registered in the item queue, then in the result queue,
// before it reaches the result ports; a line clear's held store follows the clear.
// Throughput, set by the single write port of the result queue: one character per cycle
// while it has room and no write is pending; a character opening a line waits for its store.
// Full holds for a register write and its size step, plus divide and slot for total_lines.
// Reset clears all control state and loads the register reset values at once.
module text_console_line_writer #(
  parameter int unsigned TEXT_SIZE    = 32768,
  parameter int unsigned NOTIFY_SLOTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tclw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tclw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic                                message_start_i,
  input  logic [tclw_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tclw_pkg::WL_W-1:0]           word_length_i,
  input  logic [tclw_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                kind_o,
  output logic [tclw_pkg::ROW_W-1:0]          row_o,
  output logic [tclw_pkg::COL_W-1:0]          column_o,
  output logic [tclw_pkg::CHAR_W-1:0]         char_value_o,
  output logic [tclw_pkg::OUT_SLOT_W-1:0]     notify_slot_o,
  output logic [tclw_pkg::TIME_W-1:0]         stamp_time_o,
  output logic                                last_o
);

  localparam int unsigned ItemW = $bits(tclw_pkg::item_t);
  localparam int unsigned ResW  = $bits(tclw_pkg::res_t);

  tclw_pkg::cfg_t  cfg;
  tclw_pkg::item_t front_item, back_item;
  tclw_pkg::res_t  back_res, out_res;
  logic            mid_push, mid_full, mid_empty, mid_pop;
  logic            res_push, res_full;
  logic [ItemW-1:0] mid_rdata;
  logic [ResW-1:0]  out_rdata;

  tclw_cfg #(
    .TEXT_SIZE    (TEXT_SIZE),
    .NOTIFY_SLOTS (NOTIFY_SLOTS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tclw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (push),
    .message_start_i (message_start_i),
    .char_code_i     (char_code_i),
    .word_length_i   (word_length_i),
    .now_ms_i        (now_ms_i),
    .busy_i          (cfg.busy),
    .q_full_i        (mid_full),
    .full_o          (full),
    .q_push_o        (mid_push),
    .q_item_o        (front_item)
  );

  // Decouple classification from execution
  tclw_fifo #(
    .WIDTH (ItemW),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign back_item = tclw_pkg::item_t'(mid_rdata);

  tclw_back #(
    .NOTIFY_SLOTS (NOTIFY_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (!mid_empty),
    .item_i       (back_item),
    .item_pop_o   (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // Result queue toward the text memory
  tclw_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_res       = tclw_pkg::res_t'(out_rdata);
  assign kind_o        = out_res.kind;
  assign row_o         = out_res.row;
  assign column_o      = out_res.column;
  assign char_value_o  = out_res.char_value;
  assign notify_slot_o = out_res.notify_slot;
  assign stamp_time_o  = out_res.stamp_time;
  assign last_o        = out_res.last;

endmodule
